FILE: src/cfir_pkg.sv
// Shared types and constants for the complex FIR filter.
// Used by the tap cells, the adder tree, the top level and the port checker.
`default_nettype none

package cfir_pkg;

    localparam int TAPS      = 8;
    localparam int NUM_COEF  = 8;
    localparam int SMP_W     = 16;
    localparam int COEF_W    = 2 * SMP_W;
    localparam int DATA_W    = 2 * SMP_W;
    localparam int CFG_IDX_W = 4;
    localparam int COEF_IDX_W = $clog2(NUM_COEF);
    // complex product term: difference or sum of two Q2.30 products
    localparam int PROD_W    = 2 * SMP_W + 1;
    localparam int LEVELS    = $clog2(TAPS);
    localparam int POW       = 1 << LEVELS;
    localparam int ACC_W     = PROD_W + LEVELS;
    // valid bits: window, multiply, combine, tree levels
    localparam int PIPE_D    = 3 + LEVELS;

    // real part in the low half, as on the stream
    typedef struct packed {
        logic signed [SMP_W-1:0] im;
        logic signed [SMP_W-1:0] re;
    } sample_t;

    // real part in the high half, as in the coefficient registers
    typedef struct packed {
        logic signed [SMP_W-1:0] re;
        logic signed [SMP_W-1:0] im;
    } coef_t;

    typedef struct packed {
        logic signed [PROD_W-1:0] re;
        logic signed [PROD_W-1:0] im;
    } prod_t;

endpackage

`default_nettype wire

FILE: src/complex_fir_filter_unit.sv
// Complex FIR filter, top level: coefficient registers, tap chain, adder
// tree and rounding output stage. Depends on cfir_pkg, cfir_tap_cell, cfir_add_tree.
//
// Usage:
//   Input stream s_*: one complex Q1.15 sample per transfer.
//   Output stream m_*: one complex Q1.15 result per input sample,
//   y[n] = sum of coef_k * x[n-k] over TAPS taps, rounded (half up) and
//   saturated to 16 bits.
//   Coefficients are written through cfg_wr_en/cfg_addr/cfg_wdata while the
//   stream is idle; index 0..7 selects coef_k, higher indexes are ignored.
// Timing:
//   One sample per clock sustained unless the output stalls (see Backpressure).
//   A result passes from its input transfer through delay-line load,
//   multiply and complex combine, then through the adder tree levels,
//   into the output register.
// Reset (aresetn low, synchronous): coefficients and delay line clear to
//   zero, pipeline empties, m_tvalid drops.
// Backpressure: the whole pipeline holds while a result waits in the output
//   register and m_tready is low; s_tready is low for exactly those cycles.
//   To flush the filter tail, feed zero samples.
`default_nettype none

module complex_fir_filter_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cfir_pkg::CFG_IDX_W-1:0]  cfg_addr,
    input  logic [cfir_pkg::COEF_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cfir_pkg::DATA_W-1:0]     s_tdata,   // [15:0] in_re, [31:16] in_im
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cfir_pkg::DATA_W-1:0]     m_tdata    // [15:0] out_re, [31:16] out_im
);
    import cfir_pkg::*;

    localparam int RND_W = ACC_W + 1;
    localparam logic signed [RND_W-1:0] HALF_LSB = RND_W'(1 << (SMP_W - 2));
    localparam logic signed [RND_W-1:0] Q_MAX    = RND_W'((1 << (SMP_W - 1)) - 1);
    localparam logic signed [RND_W-1:0] Q_MIN    = RND_W'(-(1 << (SMP_W - 1)));

    function automatic logic signed [SMP_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [RND_W-1:0] biased;
        logic signed [RND_W-1:0] q;
        biased = RND_W'(acc) + HALF_LSB;
        q      = biased >>> (SMP_W - 1);
        if (q > Q_MAX) begin
            round_sat = Q_MAX[SMP_W-1:0];
        end else if (q < Q_MIN) begin
            round_sat = Q_MIN[SMP_W-1:0];
        end else begin
            round_sat = q[SMP_W-1:0];
        end
    endfunction

    coef_t                   coef_reg [NUM_COEF];
    logic                    en;
    logic                    accept;
    logic [PIPE_D-1:0]       vld_reg;
    logic [PIPE_D-1:0]       vld_next;
    logic                    m_tvalid_reg;
    sample_t                 m_tdata_reg;
    sample_t                 smp_in;
    sample_t                 chain [TAPS+1];
    prod_t                   prods [TAPS];
    logic signed [ACC_W-1:0] sum_re;
    logic signed [ACC_W-1:0] sum_im;

    // pipeline moves whenever the output register is free or being drained
    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;
    assign vld_next = {vld_reg[PIPE_D-2:0], accept};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_COEF; k++) begin
                coef_reg[k] <= '0;
            end
        end else if (cfg_wr_en && (cfg_addr < CFG_IDX_W'(NUM_COEF))) begin
            coef_reg[cfg_addr[COEF_IDX_W-1:0]] <= coef_t'(cfg_wdata);
        end
    end

    assign smp_in   = sample_t'(s_tdata);
    assign chain[0] = smp_in;

    genvar g;
    generate
        for (g = 0; g < TAPS; g++) begin : g_tap
            cfir_tap_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .load    (accept),
                .smp_in  (chain[g]),
                .coef    (coef_reg[g]),
                .smp_out (chain[g+1]),
                .prod    (prods[g])
            );
        end
    endgenerate

    cfir_add_tree u_tree (
        .aclk    (aclk),
        .en      (en),
        .leaf_in (prods),
        .sum_re  (sum_re),
        .sum_im  (sum_im)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            vld_reg      <= vld_next;
            m_tvalid_reg <= vld_reg[PIPE_D-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg.re <= round_sat(sum_re);
            m_tdata_reg.im <= round_sat(sum_im);
        end
    end

    // last tap's delay-line output has no neighbor
    logic unused_tail;
    assign unused_tail = ^chain[TAPS];

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = DATA_W'(m_tdata_reg);

endmodule

`default_nettype wire

FILE: src/cfir_tap_cell.sv
// One tap of the filter: holds one sample of the delay line, passes it on
// to the next tap on each input transfer, and forms the complex product.
// Depends on cfir_pkg.
`default_nettype none

module cfir_tap_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             load,
    input  cfir_pkg::sample_t smp_in,
    input  cfir_pkg::coef_t  coef,
    output cfir_pkg::sample_t smp_out,
    output cfir_pkg::prod_t  prod
);
    import cfir_pkg::*;

    sample_t                  smp_reg;
    logic signed [2*SMP_W-1:0] rr_reg;
    logic signed [2*SMP_W-1:0] ii_reg;
    logic signed [2*SMP_W-1:0] ri_reg;
    logic signed [2*SMP_W-1:0] ir_reg;
    prod_t                    prod_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            smp_reg <= '0;
        end else if (load) begin
            smp_reg <= smp_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rr_reg      <= smp_reg.re * coef.re;
            ii_reg      <= smp_reg.im * coef.im;
            ri_reg      <= smp_reg.re * coef.im;
            ir_reg      <= smp_reg.im * coef.re;
            prod_reg.re <= PROD_W'(rr_reg) - PROD_W'(ii_reg);
            prod_reg.im <= PROD_W'(ri_reg) + PROD_W'(ir_reg);
        end
    end

    assign smp_out = smp_reg;
    assign prod    = prod_reg;

endmodule

`default_nettype wire

FILE: src/cfir_add_tree.sv
// Registered binary adder tree over the tap products, each level registered.
// Depends on cfir_pkg.
`default_nettype none

module cfir_add_tree (
    input  logic                          aclk,
    input  logic                          en,
    input  cfir_pkg::prod_t               leaf_in [cfir_pkg::TAPS],
    output logic signed [cfir_pkg::ACC_W-1:0] sum_re,
    output logic signed [cfir_pkg::ACC_W-1:0] sum_im
);
    import cfir_pkg::*;

    // heap order: node 1 is the root, children of node i are 2i and 2i+1
    logic signed [ACC_W-1:0] leaf_re [POW];
    logic signed [ACC_W-1:0] leaf_im [POW];
    logic signed [ACC_W-1:0] node_re_reg [1:POW-1];
    logic signed [ACC_W-1:0] node_im_reg [1:POW-1];

    genvar i;
    generate
        for (i = 0; i < POW; i++) begin : g_leaf
            if (i < TAPS) begin : g_used
                assign leaf_re[i] = ACC_W'(leaf_in[i].re);
                assign leaf_im[i] = ACC_W'(leaf_in[i].im);
            end else begin : g_pad
                assign leaf_re[i] = '0;
                assign leaf_im[i] = '0;
            end
        end

        for (i = 1; i < POW; i++) begin : g_node
            if (2 * i >= POW) begin : g_bottom
                always_ff @(posedge aclk) begin
                    if (en) begin
                        node_re_reg[i] <= leaf_re[2*i-POW] + leaf_re[2*i+1-POW];
                        node_im_reg[i] <= leaf_im[2*i-POW] + leaf_im[2*i+1-POW];
                    end
                end
            end else begin : g_inner
                always_ff @(posedge aclk) begin
                    if (en) begin
                        node_re_reg[i] <= node_re_reg[2*i] + node_re_reg[2*i+1];
                        node_im_reg[i] <= node_im_reg[2*i] + node_im_reg[2*i+1];
                    end
                end
            end
        end
    endgenerate

    assign sum_re = node_re_reg[1];
    assign sum_im = node_im_reg[1];

endmodule

`default_nettype wire

FILE: src/cfir_checker.sv
// Port-level checks for the complex FIR filter, attached by bind.
// Depends on cfir_pkg and complex_fir_filter_unit.
`default_nettype none

module cfir_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic [cfir_pkg::DATA_W-1:0] s_tdata,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [cfir_pkg::DATA_W-1:0] m_tdata
);
    import cfir_pkg::*;

    logic [DATA_W-1:0] unused_in;
    assign unused_in = s_tdata ^ {DATA_W{s_tvalid}};

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // input side stalls exactly while a result waits on a stalled output
    a_ready_follows_output: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // a stalled result holds its value
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

endmodule

bind complex_fir_filter_unit cfir_checker u_cfir_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for complex_fir_filter_unit: streams complex Q1.15 samples,
// predicts each filtered output in step with every input transfer and checks results.
// Depends on cfir_pkg and the complex_fir_filter_unit RTL.
`timescale 1ns / 1ps

module tb;
    import cfir_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;
    localparam int SETTLE      = PIPE_D + 4;

    localparam logic [CFG_IDX_W-1:0] REG_COEF_0    = '0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST = CFG_IDX_W'(NUM_COEF - 1);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = CFG_IDX_W'(NUM_COEF);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = {CFG_IDX_W{1'b1}};

    typedef enum {AMP_FULL, AMP_SMALL, AMP_CORNER, AMP_ZERO} amp_kind_t;
    typedef enum {TAPS_FULL, TAPS_SMALL, TAPS_SPARSE} coef_style_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [COEF_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [DATA_W-1:0]    s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [DATA_W-1:0]    m_tdata;

    complex_fir_filter_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // filter state as the block should hold it
    coef_t   tap_coef [NUM_COEF]  = '{default: '0};
    sample_t delay_line [TAPS-1]  = '{default: '0};

    sample_t samples_to_send [$];
    sample_t expected_y [$];
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      mismatches = 0;
    int      cycle_count = 0;

    logic [15:0] corner_vals [5] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic logic signed [15:0] round_saturate(longint acc);
        longint q;
        q = (acc + 64'sd16384) >>> 15;   // half LSB up, then floor
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    // y[n] for the new sample, then shift it into the delay line
    function automatic sample_t filter_step(sample_t x);
        longint  acc_re;
        longint  acc_im;
        sample_t s;
        sample_t y;
        acc_re = 0;
        acc_im = 0;
        for (int k = 0; k < TAPS; k++) begin
            s = (k == 0) ? x : delay_line[k-1];
            acc_re += longint'(s.re) * longint'(tap_coef[k].re)
                    - longint'(s.im) * longint'(tap_coef[k].im);
            acc_im += longint'(s.re) * longint'(tap_coef[k].im)
                    + longint'(s.im) * longint'(tap_coef[k].re);
        end
        for (int k = TAPS - 2; k > 0; k--) begin
            delay_line[k] = delay_line[k-1];
        end
        delay_line[0] = x;
        y.re = round_saturate(acc_re);
        y.im = round_saturate(acc_im);
        return y;
    endfunction

    // input side: a transfer updates the prediction, then the next sample goes out
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_y.push_back(filter_step(sample_t'(s_tdata)));
            end
            if (!s_tvalid || s_tready) begin
                if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= samples_to_send.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // output side: check each transfer against the oldest predicted output
    always @(posedge aclk) begin
        sample_t got;
        sample_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_y.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output re=%0d im=%0d", got.re, got.im);
                end else begin
                    want = expected_y.pop_front();
                    if (got.re !== want.re || got.im !== want.im) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected re=%0d im=%0d, got re=%0d im=%0d",
                                     want.re, want.im, got.re, got.im);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx <= REG_COEF_LAST)
            tap_coef[idx] = val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic write_all_coefs(input logic [COEF_W-1:0] val);
        for (int k = 0; k < NUM_COEF; k++)
            write_reg(REG_COEF_0 + CFG_IDX_W'(k), val);
    endtask

    // block is idle once every sample went in and every output came back
    task automatic wait_idle();
        while (samples_to_send.size() != 0 || s_tvalid || expected_y.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic sample_t mk(input int re, input int im);
        sample_t s;
        s.re = re[15:0];
        s.im = im[15:0];
        return s;
    endfunction

    function automatic logic [15:0] rand_part(input amp_kind_t kind);
        case (kind)
            AMP_FULL:   return 16'($urandom);
            AMP_SMALL:  return 16'($urandom_range(512) - 256);
            AMP_CORNER: return corner_vals[$urandom_range(4)];
            default:    return '0;
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef(input coef_style_t style);
        logic [15:0] re;
        logic [15:0] im;
        case (style)
            TAPS_SMALL: begin
                re = 16'($urandom_range(8190) - 4095);
                im = 16'($urandom_range(8190) - 4095);
                return {re, im};
            end
            TAPS_SPARSE: return ($urandom_range(1) == 0) ? '0 : COEF_W'($urandom);
            default:     return $urandom;
        endcase
    endfunction

    // runs of one amplitude class; zero runs of TAPS - 1 or more samples also flush the delay line
    task automatic queue_random(input int n);
        int        queued;
        int        run_len;
        int        r;
        amp_kind_t kind;
        sample_t   s;
        queued = 0;
        while (queued < n) begin
            r = $urandom_range(99);
            kind = (r < 55) ? AMP_FULL : (r < 75) ? AMP_SMALL : (r < 88) ? AMP_CORNER : AMP_ZERO;
            run_len = $urandom_range(1, 16);
            for (int i = 0; i < run_len && queued < n; i++) begin
                s.re = rand_part(kind);
                s.im = rand_part(kind);
                samples_to_send.push_back(s);
                queued++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // coefficients still at reset: output must be zero
        send_idle_pct = 33;
        recv_idle_pct = 66;
        samples_to_send.push_back(mk(32767, -32768));
        wait_idle();

        // full-scale positive taps, writes past the last tap must be ignored
        write_all_coefs(32'h7FFF_7FFF);
        write_reg(REG_SPARE_LO, 32'h1234_5678);
        write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
        samples_to_send.push_back(mk(32767, 32767));
        samples_to_send.push_back(mk(-32768, -32768));
        samples_to_send.push_back(mk(32767, -32768));
        samples_to_send.push_back(mk(-32768, 32767));
        repeat (TAPS - 1) samples_to_send.push_back(mk(0, 0));
        wait_idle();

        // full-scale negative taps
        write_all_coefs(32'h8000_8000);
        samples_to_send.push_back(mk(-32768, -32768));
        samples_to_send.push_back(mk(32767, 32767));
        samples_to_send.push_back(mk(1, -1));
        repeat (4) samples_to_send.push_back(mk(0, 0));
        wait_idle();

        // single half-scale tap: exact halves must round up
        write_all_coefs('0);
        write_reg(REG_COEF_0, 32'h4000_0000);
        samples_to_send.push_back(mk(1, 0));
        samples_to_send.push_back(mk(-1, 0));
        samples_to_send.push_back(mk(3, -3));
        samples_to_send.push_back(mk(0, -1));
        wait_idle();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 66 : 0;
            recv_idle_pct = (phase == 0) ? 66 : (phase == 1) ? 33 : 0;
            for (int k = 0; k < NUM_COEF; k++)
                write_reg(REG_COEF_0 + CFG_IDX_W'(k), rand_coef(coef_style_t'(phase)));
            queue_random(415);
            wait_idle();
        end

        if (mismatches == 0 && expected_y.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/cfir_pkg.sv
src/cfir_tap_cell.sv
src/cfir_add_tree.sv
src/complex_fir_filter_unit.sv
src/cfir_checker.sv
tb/tb.sv
